// ===== sv/bmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf_pkg
// Types and constants shared by the box mean filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

    localparam int GRAY_W   = 8;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 16;
    localparam int WS_W     = 3;
    localparam int IW_W     = 11;
    localparam int IH_W     = 16;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int QUOT_W   = 8;

    localparam logic [1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic              frame_start;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [GRAY_W-1:0] mean;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/bmf_cell.sv =====
// ----------------------------------------------------------------------------
// bmf_cell
// One window column: holds a column sum, passes it on, adds it to the window sum when IDX < n.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_cell #(
    parameter int IDX   = 0,
    parameter int CSW   = 11,
    parameter int WSW   = 14,
    parameter int NW    = 3
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           shift,
    input  wire logic [CSW-1:0] din,
    input  wire logic [NW-1:0]  n,
    input  wire logic [WSW-1:0] acc_in,
    output logic      [CSW-1:0] dout,
    output logic      [WSW-1:0] acc_out
);

    logic [CSW-1:0] val_reg;
    logic [CSW-1:0] val_next;

    always_comb
    begin
        val_next = shift ? din : val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

    assign dout    = val_reg;
    assign acc_out = (32'(n) > IDX) ? acc_in + WSW'(val_reg) : acc_in;

endmodule

`default_nettype wire

// ===== sv/bmf_div.sv =====
// ----------------------------------------------------------------------------
// bmf_div
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_div #(
    parameter int NUMW = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [NUMW-1:0]             num,
    input  wire logic [NUMW-1:0]             den,
    output logic                             done,
    output logic [bmf_pkg::QUOT_W-1:0]       quot
);

    localparam int QW = bmf_pkg::QUOT_W;
    localparam int CNTW = $clog2(QW + 1);

    logic [NUMW-1:0] rem_reg, rem_next;
    logic [NUMW-1:0] dsh_reg, dsh_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = num;
            dsh_next = den << (QW - 1);
            cnt_next = CNTW'(QW);
        end
        else if (cnt_reg != '0)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNTW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ===== sv/box_mean_filter.sv =====
// ----------------------------------------------------------------------------
// box_mean_filter
// N-by-N box mean over a raster pixel stream, line store plus column cells.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_data  (gray, frame_start)
// out       output     out_valid / out_stall out_data (col, row, mean)
// cfg       input      APB-style            window_size, image_width, image_height
//
// One item at a time: a border pixel goes through S_IDLE, S_READ and S_SUM; an interior pixel
// goes on through S_DIV (divider wait) and S_OUT (output load), plus any out stall.
// Line store is one memory row per column; its contents need no reset.
// The output register holds a result while the next item is read in.
// ----------------------------------------------------------------------------
`default_nettype none

module box_mean_filter #(
    parameter int MAX_WINDOW = 7,
    parameter int MAX_WIDTH  = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire bmf_pkg::in_item_t                in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output bmf_pkg::out_item_t                    out_data,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bmf_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [bmf_pkg::PDATA_W-1:0]      pwdata,
    output logic      [bmf_pkg::PDATA_W-1:0]      prdata,
    output logic                                  pready
);

    localparam int LS_ROWS = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
    localparam int LSW     = 8 * LS_ROWS;
    localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int NW      = $clog2(MAX_WINDOW + 1);
    localparam int CAP     = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
    localparam int CSW     = $clog2(MAX_WINDOW * 255 + 1);
    localparam int WSW     = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int NUMW    = WSW + 2;
    localparam int RW      = bmf_pkg::ROW_W;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_SUM, S_DIV, S_OUT} state_t;

    // configuration
    logic [bmf_pkg::WS_W-1:0] ws_reg;
    logic [bmf_pkg::IW_W-1:0] iw_reg;
    logic [bmf_pkg::IH_W-1:0] ih_reg;
    logic                     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= 3'd3;
            iw_reg <= 11'd1024;
            ih_reg <= 16'd1024;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                bmf_pkg::REG_WINDOW_SIZE:  ws_reg <= pwdata[bmf_pkg::WS_W-1:0];
                bmf_pkg::REG_IMAGE_WIDTH:  iw_reg <= pwdata[bmf_pkg::IW_W-1:0];
                bmf_pkg::REG_IMAGE_HEIGHT: ih_reg <= pwdata[bmf_pkg::IH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            bmf_pkg::REG_WINDOW_SIZE:  prdata = 32'(ws_reg);
            bmf_pkg::REG_IMAGE_WIDTH:  prdata = 32'(iw_reg);
            bmf_pkg::REG_IMAGE_HEIGHT: prdata = 32'(ih_reg);
            default:                   prdata = '0;
        endcase
    end

    // effective sizes
    logic [bmf_pkg::WS_W-1:0] ws_odd;
    logic [NW-1:0]            n;
    logic [CW:0]              w_eff;
    logic [RW-1:0]            h_eff;
    logic [7:0]               nn;
    logic [NW-1:0]            half;

    always_comb
    begin
        ws_odd = ws_reg | bmf_pkg::WS_W'(1);
        if (32'(ws_odd) > CAP)
            n = NW'(CAP);
        else
            n = NW'(ws_odd);
        if (iw_reg == '0)
            w_eff = (CW+1)'(1);
        else if (32'(iw_reg) > MAX_WIDTH)
            w_eff = (CW+1)'(MAX_WIDTH);
        else
            w_eff = (CW+1)'(iw_reg);
        h_eff = (ih_reg == '0) ? RW'(1) : ih_reg;
        nn    = 8'(n) * 8'(n);
        half  = (n - 1'b1) >> 1;
    end

    // control and position
    state_t              state_reg, state_next;
    logic [CW-1:0]       ccnt_reg, ccnt_next;
    logic [RW-1:0]       rcnt_reg, rcnt_next;
    logic [CW-1:0]       c_reg, c_next;
    logic [RW-1:0]       r_reg, r_next;
    logic [7:0]          gray_reg, gray_next;
    logic                prod_reg, prod_next;
    logic                ovalid_reg, ovalid_next;
    bmf_pkg::out_item_t  odata_reg, odata_next;
    logic                accept;
    logic [CW:0]         c1;
    logic [RW:0]         r1;
    logic                div_start;
    logic                div_done;
    logic [7:0]          quot;
    logic [NUMW-1:0]     den;
    logic [WSW-1:0]      wsum;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        state_next  = state_reg;
        ccnt_next   = ccnt_reg;
        rcnt_next   = rcnt_reg;
        c_next      = c_reg;
        r_next      = r_reg;
        gray_next   = gray_reg;
        prod_next   = prod_reg;
        odata_next  = odata_reg;
        ovalid_next = ovalid_reg & out_stall;
        div_start   = 1'b0;
        c1          = '0;
        r1          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    c_next    = in_data.frame_start ? '0 : ccnt_reg;
                    r_next    = in_data.frame_start ? '0 : rcnt_reg;
                    gray_next = in_data.gray;
                    c1 = {1'b0, c_next} + 1'b1;
                    r1 = {1'b0, r_next} + 1'b1;
                    if (c1 >= w_eff)
                    begin
                        ccnt_next = '0;
                        rcnt_next = (r1 >= {1'b0, h_eff}) ? '0 : r1[RW-1:0];
                    end
                    else
                    begin
                        ccnt_next = c1[CW-1:0];
                        rcnt_next = r_next;
                    end
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                prod_next = ({1'b0, c_reg} < w_eff) && (r_reg < h_eff)
                            && (32'(c_reg) + 1 >= 32'(n)) && (32'(r_reg) + 1 >= 32'(n));
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (prod_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next     = 1'b1;
                    odata_next.col  = bmf_pkg::COL_W'(c_reg - CW'(half));
                    odata_next.row  = r_reg - RW'(half);
                    odata_next.mean = quot;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ccnt_reg   <= '0;
            rcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
            prod_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ccnt_reg   <= ccnt_next;
            rcnt_reg   <= rcnt_next;
            ovalid_reg <= ovalid_next;
            prod_reg   <= prod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        r_reg     <= r_next;
        gray_reg  <= gray_next;
        odata_reg <= odata_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    // line store: one word per column, oldest line in the low byte
    logic [LSW-1:0] ls_mem [MAX_WIDTH];
    logic [LSW-1:0] rd_reg;
    logic [LSW-1:0] wr_word;
    logic [CSW-1:0] colsum;

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= ls_mem[c_next];
        if (state_reg == S_READ)
            ls_mem[c_reg] <= wr_word;
    end

    always_comb
    begin
        wr_word = rd_reg;
        for (int t = 0; t + 1 < LS_ROWS; t++)
            wr_word[t*8 +: 8] = rd_reg[(t+1)*8 +: 8];
        wr_word[(LS_ROWS-1)*8 +: 8] = gray_reg;
        colsum = CSW'(gray_reg);
        for (int t = 0; t + 1 < MAX_WINDOW; t++)
            if (t + 32'(n) >= MAX_WINDOW)
                colsum = colsum + CSW'(rd_reg[t*8 +: 8]);
    end

    // column cells, newest at index 0
    logic [CSW-1:0] cd   [MAX_WINDOW+1];
    logic [WSW-1:0] acc  [MAX_WINDOW+1];

    assign cd[0]  = colsum;
    assign acc[0] = '0;

    for (genvar k = 0; k < MAX_WINDOW; k++)
    begin : g_cell
        bmf_cell #(
            .IDX (k),
            .CSW (CSW),
            .WSW (WSW),
            .NW  (NW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (state_reg == S_READ),
            .din     (cd[k]),
            .n       (n),
            .acc_in  (acc[k]),
            .dout    (cd[k+1]),
            .acc_out (acc[k+1])
        );
    end

    assign wsum = acc[MAX_WINDOW];
    assign den  = NUMW'({nn, 1'b0});

    logic [NUMW-1:0] num_full;
    assign num_full = NUMW'({wsum, 1'b0}) + NUMW'(nn);

    bmf_div #(
        .NUMW (NUMW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_full),
        .den   (den),
        .done  (div_done),
        .quot  (quot)
    );

endmodule

`default_nettype wire
